// ===== rtl/jsu_pkg.sv =====
// package with the types and constants shared by the json string unescape unit
package jsu_pkg;

    // result kinds
    typedef enum logic [2:0] {
        K_DATA   = 3'd0,
        K_END    = 3'd1,
        K_UNTERM = 3'd2,
        K_BADESC = 3'd3,
        K_BADUNI = 3'd4
    } t_kind;

    // input request: one byte of the string body
    typedef struct packed {
        logic [7:0] data_byte;
        logic       closing_single;
    } t_in;

    // output request: one result
    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] kind;
        logic       last;
    } t_out;

    localparam int unsigned MaxResults = 4;
    localparam int unsigned CntW       = 3;

    // the results caused by one input byte, handed from decoder to result buffer
    typedef struct packed {
        logic [CntW-1:0]             cnt;
        t_kind                       kind;
        logic [MaxResults-1:0][7:0]  bytes;
    } t_burst;

    // characters
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_U      = 8'h75;

    // utf-8 and surrogate constants
    localparam logic [15:0] SURR_HI_LO  = 16'hD800;
    localparam logic [15:0] SURR_HI_TOP = 16'hDBFF;
    localparam logic [20:0] PLANE1      = 21'h10000;
    localparam logic [20:0] MAX1        = 21'h00007F;
    localparam logic [20:0] MAX2        = 21'h0007FF;
    localparam logic [20:0] MAX3        = 21'h00FFFF;
    localparam logic [7:0]  LEAD2       = 8'hC0;
    localparam logic [7:0]  LEAD3       = 8'hE0;
    localparam logic [7:0]  LEAD4       = 8'hF0;
    localparam logic [7:0]  CONT        = 8'h80;

endpackage

// ===== rtl/jsu_decode.sv =====
// escape decoder: phase state and utf-8 encoding of one byte into a burst of results
module jsu_decode (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  jsu_pkg::t_in   i_req,
    output jsu_pkg::t_burst o_burst
);

    localparam int unsigned CntW_L = jsu_pkg::CntW;

    typedef enum logic [2:0] {
        PH_TEXT    = 3'd0,
        PH_ESC     = 3'd1,
        PH_HEX     = 3'd2,
        PH_PAIR_BS = 3'd3,
        PH_PAIR_U  = 3'd4
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_digits, n_digits;
    logic [15:0] r_hex, n_hex;
    logic [9:0]  r_high, n_high;
    logic        r_in_pair, n_in_pair;

    logic [7:0]  c;
    logic [7:0]  quote;
    logic        d_ok;
    logic [3:0]  d_val;
    logic [15:0] hex_new;
    logic [20:0] cp;
    logic [20:0] pair_cp;
    logic [CntW_L-1:0] u_cnt;
    logic [3:0][7:0]   u_bytes;

    assign c     = i_req.data_byte;
    assign quote = i_req.closing_single ? jsu_pkg::CH_SQUOTE : jsu_pkg::CH_DQUOTE;

    // hex digit in either case
    always_comb begin
        d_ok  = 1'b1;
        d_val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d_val = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d_val = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d_val = 4'(c - 8'h37);
        end else begin
            d_ok = 1'b0;
        end
    end

    assign hex_new = {r_hex[11:0], d_val};
    assign pair_cp = jsu_pkg::PLANE1 + {1'b0, r_high, hex_new[9:0]};
    assign cp      = r_in_pair ? pair_cp : {5'd0, hex_new};

    // utf-8 encoding of the finished code point
    always_comb begin
        u_bytes = '0;
        if (cp <= jsu_pkg::MAX1) begin
            u_cnt      = CntW_L'(1);
            u_bytes[0] = cp[7:0];
        end else if (cp <= jsu_pkg::MAX2) begin
            u_cnt      = CntW_L'(2);
            u_bytes[0] = jsu_pkg::LEAD2 | {3'd0, cp[10:6]};
            u_bytes[1] = jsu_pkg::CONT | {2'd0, cp[5:0]};
        end else if (cp <= jsu_pkg::MAX3) begin
            u_cnt      = CntW_L'(3);
            u_bytes[0] = jsu_pkg::LEAD3 | {4'd0, cp[15:12]};
            u_bytes[1] = jsu_pkg::CONT | {2'd0, cp[11:6]};
            u_bytes[2] = jsu_pkg::CONT | {2'd0, cp[5:0]};
        end else begin
            u_cnt      = CntW_L'(4);
            u_bytes[0] = jsu_pkg::LEAD4 | {5'd0, cp[20:18]};
            u_bytes[1] = jsu_pkg::CONT | {2'd0, cp[17:12]};
            u_bytes[2] = jsu_pkg::CONT | {2'd0, cp[11:6]};
            u_bytes[3] = jsu_pkg::CONT | {2'd0, cp[5:0]};
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_digits  = r_digits;
        n_hex     = r_hex;
        n_high    = r_high;
        n_in_pair = r_in_pair;
        o_burst   = '0;
        o_burst.kind = jsu_pkg::K_DATA;

        case (r_phase)
            PH_ESC: begin
                n_phase = PH_TEXT;
                o_burst.cnt = CntW_L'(1);
                case (c)
                    jsu_pkg::CH_B: o_burst.bytes[0] = 8'h08;
                    jsu_pkg::CH_T: o_burst.bytes[0] = 8'h09;
                    jsu_pkg::CH_N: o_burst.bytes[0] = 8'h0A;
                    jsu_pkg::CH_F: o_burst.bytes[0] = 8'h0C;
                    jsu_pkg::CH_R: o_burst.bytes[0] = 8'h0D;
                    jsu_pkg::CH_DQUOTE, jsu_pkg::CH_SQUOTE,
                    jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: o_burst.bytes[0] = c;
                    jsu_pkg::CH_U: begin
                        o_burst.cnt = '0;
                        n_phase     = PH_HEX;
                        n_digits    = 2'd0;
                        n_hex       = '0;
                        n_in_pair   = 1'b0;
                    end
                    default: begin
                        o_burst.kind = jsu_pkg::K_BADESC;
                        n_digits  = 2'd0;
                        n_hex     = '0;
                        n_high    = '0;
                        n_in_pair = 1'b0;
                    end
                endcase
            end
            PH_HEX: begin
                if (!d_ok) begin
                    o_burst.cnt  = CntW_L'(1);
                    o_burst.kind = jsu_pkg::K_BADUNI;
                    n_phase   = PH_TEXT;
                    n_digits  = 2'd0;
                    n_hex     = '0;
                    n_high    = '0;
                    n_in_pair = 1'b0;
                end else if (r_digits != 2'd3) begin
                    n_hex    = hex_new;
                    n_digits = r_digits + 2'd1;
                end else if (!r_in_pair && hex_new >= jsu_pkg::SURR_HI_LO
                             && hex_new <= jsu_pkg::SURR_HI_TOP) begin
                    // high surrogate: wait for the second escape
                    n_high   = hex_new[9:0];
                    n_hex    = '0;
                    n_digits = 2'd0;
                    n_phase  = PH_PAIR_BS;
                end else begin
                    o_burst.cnt   = u_cnt;
                    o_burst.bytes = u_bytes;
                    n_phase   = PH_TEXT;
                    n_digits  = 2'd0;
                    n_hex     = '0;
                    n_high    = '0;
                    n_in_pair = 1'b0;
                end
            end
            PH_PAIR_BS, PH_PAIR_U: begin
                if (c != (r_phase == PH_PAIR_BS ? jsu_pkg::CH_BSLASH : jsu_pkg::CH_U)) begin
                    o_burst.cnt  = CntW_L'(1);
                    o_burst.kind = jsu_pkg::K_BADUNI;
                    n_phase   = PH_TEXT;
                    n_digits  = 2'd0;
                    n_hex     = '0;
                    n_high    = '0;
                    n_in_pair = 1'b0;
                end else if (r_phase == PH_PAIR_BS) begin
                    n_phase = PH_PAIR_U;
                end else begin
                    n_phase   = PH_HEX;
                    n_digits  = 2'd0;
                    n_hex     = '0;
                    n_in_pair = 1'b1;
                end
            end
            default: begin
                n_phase = PH_TEXT;
                if (c == 8'h00 || c == quote) begin
                    o_burst.cnt  = CntW_L'(1);
                    o_burst.kind = (c == 8'h00) ? jsu_pkg::K_UNTERM : jsu_pkg::K_END;
                    n_digits  = 2'd0;
                    n_hex     = '0;
                    n_high    = '0;
                    n_in_pair = 1'b0;
                end else if (c == jsu_pkg::CH_BSLASH) begin
                    n_phase = PH_ESC;
                end else begin
                    o_burst.cnt      = CntW_L'(1);
                    o_burst.bytes[0] = c;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_TEXT;
            r_digits  <= 2'd0;
            r_hex     <= '0;
            r_high    <= '0;
            r_in_pair <= 1'b0;
        end else if (i_take) begin
            r_phase   <= n_phase;
            r_digits  <= n_digits;
            r_hex     <= n_hex;
            r_high    <= n_high;
            r_in_pair <= n_in_pair;
        end
    end

    a_pair_in_hex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_pair |-> r_phase == PH_HEX)
        else $error("pair flag set outside hex phase");

    a_digits_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_HEX |-> r_digits == 2'd0)
        else $error("digit count left over outside hex phase");

endmodule

// ===== rtl/jsu_burst.sv =====
// result buffer: holds the burst for one input byte and sends it one result a cycle while the output does not stall
module jsu_burst (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  jsu_pkg::t_burst i_burst,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    output jsu_pkg::t_out   o_out_req,
    output logic            o_in_stall
);

    localparam int unsigned CntW = jsu_pkg::CntW;
    localparam int unsigned MaxR = jsu_pkg::MaxResults;

    logic [CntW-1:0]          r_cnt, n_cnt;
    jsu_pkg::t_kind           r_kind;
    logic [MaxR-1:0][7:0]     r_bytes;
    logic                     take;

    assign o_out_valid        = (r_cnt != '0);
    assign take               = o_out_valid && !i_out_stall;
    assign o_out_req.out_byte = r_bytes[0];
    assign o_out_req.kind     = r_kind;
    assign o_out_req.last     = (r_cnt == CntW'(1));

    // accept a new byte when the buffer is empty or its last result leaves now
    assign o_in_stall = (r_cnt > CntW'(1)) || ((r_cnt == CntW'(1)) && i_out_stall);

    always_comb begin
        n_cnt = r_cnt;
        if (i_load) begin
            n_cnt = i_burst.cnt;
        end else if (take) begin
            n_cnt = r_cnt - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_kind  <= i_burst.kind;
            r_bytes <= i_burst.bytes;
        end else if (take) begin
            r_bytes <= {8'h00, r_bytes[MaxR-1:1]};
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(MaxR))
        else $error("result count out of range");

    a_stop_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_kind != jsu_pkg::K_DATA) |-> r_cnt == CntW'(1))
        else $error("end or error result not alone");

    a_load_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (r_cnt == '0 || (r_cnt == CntW'(1) && !i_out_stall)))
        else $error("burst loaded over pending results");

endmodule

// ===== rtl/json_string_unescape_utf8_unit.sv =====
// top level of the json string unescape unit with utf-8 output
// results are registered: a result appears in the cycle after the byte that causes it is accepted
// throughput: one byte a cycle while each byte gives at most one result and the output does not stall;
//   a \u escape that completes a code point gives up to four bytes, one a cycle when not stalled,
//   and holds the input until its last byte leaves
// reset: synchronous, active low; clears the phase to normal text and empties the buffer
module json_string_unescape_utf8_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // input channel: one byte of the string body per request
    input  logic          i_in_valid,
    input  jsu_pkg::t_in  i_in_req,
    output logic          o_in_stall,
    // output channel: one result per request
    output logic          o_out_valid,
    output jsu_pkg::t_out o_out_req,
    input  logic          i_out_stall
);

    // byte accepted this cycle
    logic            take;
    // results caused by the accepted byte, straight from the decoder
    jsu_pkg::t_burst burst;

    assign take = i_in_valid && !o_in_stall;

    // phase, hex digits and surrogate state; decodes the byte into 0..4 results
    jsu_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_req   (i_in_req),
        .o_burst (burst)
    );

    // result register; a byte with no result loads an empty burst
    jsu_burst u_burst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (take),
        .i_burst     (burst),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_req   (o_out_req),
        .o_in_stall  (o_in_stall)
    );

    // every result request is marked last exactly once per burst
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out_req.last) |=> o_out_valid)
        else $error("burst ended without a last result");

endmodule

// ===== verif/json_string_unescape_utf8_unit_test.sv =====
// testbench for the json string unescape unit: byte stream stimulus, utf-8 result checking
module json_string_unescape_utf8_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    // no-progress limit for the watchdog, in cycles
    localparam int unsigned StallLimit   = 4000;
    // length of the long receiver hold-off that makes the unit back up
    localparam int unsigned HoldOffCycles = 80;
    // input requests sent in each random phase
    localparam int unsigned PhaseItems    = 100;
    // cycles allowed after the last result before the verdict
    localparam int unsigned DrainCycles   = 8;

    // byte values produced by the simple escapes, the zero byte, and those used to build hex digits
    localparam logic [7:0] NUL          = 8'h00;
    localparam logic [7:0] BACKSPACE    = 8'h08;
    localparam logic [7:0] TAB          = 8'h09;
    localparam logic [7:0] LINE_FEED    = 8'h0A;
    localparam logic [7:0] FORM_FEED    = 8'h0C;
    localparam logic [7:0] CARRIAGE_RET = 8'h0D;
    localparam logic [7:0] DIG_0        = 8'h30;
    localparam logic [7:0] LOW_A        = 8'h61;
    localparam logic [7:0] UP_A         = 8'h41;

    // letters that may follow a backslash, apart from u
    localparam logic [7:0] ESC_LETTERS [9] = '{
        jsu_pkg::CH_B, jsu_pkg::CH_T, jsu_pkg::CH_N, jsu_pkg::CH_F, jsu_pkg::CH_R,
        jsu_pkg::CH_DQUOTE, jsu_pkg::CH_SQUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH};

    // where the decoder stands within the string body
    typedef enum logic [2:0] {
        SCAN_TEXT,
        SCAN_ESCAPE,
        SCAN_HEX,
        SCAN_PAIR_BSLASH,
        SCAN_PAIR_U
    } t_scan;

    // tracks the decoder state, works out the utf-8 results of each accepted
    // byte and checks the results that come out in order
    class utf8_tracker;
        t_scan         scan;
        logic [1:0]    digits;
        logic [15:0]   hex_acc;
        logic [9:0]    high_bits;
        bit            second_half;
        jsu_pkg::t_out awaited_results[$];
        int unsigned   errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            scan        = SCAN_TEXT;
            digits      = 2'd0;
            hex_acc     = 16'h0000;
            high_bits   = 10'h000;
            second_half = 1'b0;
        endfunction

        function bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
            v = 4'h0;
            if (c >= DIG_0 && c <= DIG_0 + 8'd9) begin
                v = 4'(c - DIG_0);
                return 1'b1;
            end
            if (c >= LOW_A && c <= LOW_A + 8'd5) begin
                v = 4'(c - LOW_A + 8'd10);
                return 1'b1;
            end
            if (c >= UP_A && c <= UP_A + 8'd5) begin
                v = 4'(c - UP_A + 8'd10);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void push_result(logic [7:0] b, jsu_pkg::t_kind k, bit fin);
            jsu_pkg::t_out r;
            r.out_byte = b;
            r.kind     = k;
            r.last     = fin;
            awaited_results.push_back(r);
        endfunction

        // end of string or error: a single result, back to text
        function void abort(jsu_pkg::t_kind k);
            push_result(NUL, k, 1'b1);
            restart();
        endfunction

        function void emit_code_point(logic [20:0] cp);
            logic [7:0] seq [4];
            int n;
            if (cp <= jsu_pkg::MAX1) begin
                seq[0] = cp[7:0];
                n = 1;
            end else if (cp <= jsu_pkg::MAX2) begin
                seq[0] = jsu_pkg::LEAD2 | {3'b000, cp[10:6]};
                seq[1] = jsu_pkg::CONT  | {2'b00, cp[5:0]};
                n = 2;
            end else if (cp <= jsu_pkg::MAX3) begin
                seq[0] = jsu_pkg::LEAD3 | {4'h0, cp[15:12]};
                seq[1] = jsu_pkg::CONT  | {2'b00, cp[11:6]};
                seq[2] = jsu_pkg::CONT  | {2'b00, cp[5:0]};
                n = 3;
            end else begin
                seq[0] = jsu_pkg::LEAD4 | {5'b00000, cp[20:18]};
                seq[1] = jsu_pkg::CONT  | {2'b00, cp[17:12]};
                seq[2] = jsu_pkg::CONT  | {2'b00, cp[11:6]};
                seq[3] = jsu_pkg::CONT  | {2'b00, cp[5:0]};
                n = 4;
            end
            for (int i = 0; i < n; i++) begin
                push_result(seq[i], jsu_pkg::K_DATA, i == n - 1);
            end
        endfunction

        // one accepted input request
        function void take_byte(jsu_pkg::t_in req);
            logic [7:0]  c;
            logic [7:0]  quote;
            logic [3:0]  nib;
            logic [20:0] cp;
            c     = req.data_byte;
            quote = req.closing_single ? jsu_pkg::CH_SQUOTE : jsu_pkg::CH_DQUOTE;
            case (scan)
                SCAN_ESCAPE: begin
                    scan = SCAN_TEXT;
                    case (c)
                        jsu_pkg::CH_B: push_result(BACKSPACE, jsu_pkg::K_DATA, 1'b1);
                        jsu_pkg::CH_T: push_result(TAB, jsu_pkg::K_DATA, 1'b1);
                        jsu_pkg::CH_N: push_result(LINE_FEED, jsu_pkg::K_DATA, 1'b1);
                        jsu_pkg::CH_F: push_result(FORM_FEED, jsu_pkg::K_DATA, 1'b1);
                        jsu_pkg::CH_R: push_result(CARRIAGE_RET, jsu_pkg::K_DATA, 1'b1);
                        jsu_pkg::CH_DQUOTE, jsu_pkg::CH_SQUOTE,
                        jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH:
                            push_result(c, jsu_pkg::K_DATA, 1'b1);
                        jsu_pkg::CH_U: begin
                            scan        = SCAN_HEX;
                            digits      = 2'd0;
                            hex_acc     = 16'h0000;
                            second_half = 1'b0;
                        end
                        default: abort(jsu_pkg::K_BADESC);
                    endcase
                end
                SCAN_HEX: begin
                    if (!hex_nibble(c, nib)) begin
                        abort(jsu_pkg::K_BADUNI);
                    end else begin
                        hex_acc = {hex_acc[11:0], nib};
                        if (digits != 2'd3) begin
                            digits++;
                        end else if (second_half) begin
                            // low ten bits taken as they are, no low surrogate check
                            cp = jsu_pkg::PLANE1 + {high_bits, 10'h000} + hex_acc[9:0];
                            restart();
                            emit_code_point(cp);
                        end else if (hex_acc >= jsu_pkg::SURR_HI_LO
                                     && hex_acc <= jsu_pkg::SURR_HI_TOP) begin
                            high_bits = hex_acc[9:0];
                            hex_acc   = 16'h0000;
                            digits    = 2'd0;
                            scan      = SCAN_PAIR_BSLASH;
                        end else begin
                            cp = {5'b00000, hex_acc};
                            restart();
                            emit_code_point(cp);
                        end
                    end
                end
                SCAN_PAIR_BSLASH: begin
                    if (c != jsu_pkg::CH_BSLASH) begin
                        abort(jsu_pkg::K_BADUNI);
                    end else begin
                        scan = SCAN_PAIR_U;
                    end
                end
                SCAN_PAIR_U: begin
                    if (c != jsu_pkg::CH_U) begin
                        abort(jsu_pkg::K_BADUNI);
                    end else begin
                        scan        = SCAN_HEX;
                        digits      = 2'd0;
                        hex_acc     = 16'h0000;
                        second_half = 1'b1;
                    end
                end
                default: begin
                    scan = SCAN_TEXT;
                    if (c == NUL) begin
                        abort(jsu_pkg::K_UNTERM);
                    end else if (c == jsu_pkg::CH_BSLASH) begin
                        scan = SCAN_ESCAPE;
                    end else if (c == quote) begin
                        abort(jsu_pkg::K_END);
                    end else begin
                        push_result(c, jsu_pkg::K_DATA, 1'b1);
                    end
                end
            endcase
        endfunction

        function void report(string field, int unsigned want, int unsigned got);
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            errors++;
        endfunction

        // one accepted result request
        function void check_result(jsu_pkg::t_out got);
            jsu_pkg::t_out want;
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual byte %0h kind %0d last %0b",
                         $time, got.out_byte, got.kind, got.last);
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            if (got.out_byte !== want.out_byte) report("out_byte", want.out_byte, got.out_byte);
            if (got.kind !== want.kind) report("kind", want.kind, got.kind);
            if (got.last !== want.last) report("last", want.last, got.last);
        endfunction
    endclass

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          i_in_valid;
    jsu_pkg::t_in  i_in_req;
    logic          o_in_stall;
    logic          o_out_valid;
    jsu_pkg::t_out o_out_req;
    logic          i_out_stall;

    utf8_tracker tracker = new();

    // idling percentages of the current phase
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    // asks the receiver for one long hold-off
    bit          hold_off_go   = 1'b0;
    int unsigned items_sent    = 0;
    int unsigned quiet_cycles  = 0;
    // bytes of the piece of string body being built
    logic [7:0]  piece [$];

    json_string_unescape_utf8_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_req    (i_in_req),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_req   (o_out_req),
        .i_out_stall (i_out_stall)
    );

    always #1 i_clk = ~i_clk;

    // receiver: random stall at the falling edge, or one long hold-off on request,
    // counted here so the sender keeps offering requests meanwhile
    initial i_out_stall = 1'b0;
    always begin
        @(negedge i_clk);
        if (hold_off_go) begin
            hold_off_go = 1'b0;
            i_out_stall <= 1'b1;
            repeat (HoldOffCycles) @(negedge i_clk);
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // every accepted result is checked against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tracker.check_result(o_out_req);
        end
    end

    // watchdog: counts cycles in which neither channel moves a request
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= StallLimit) begin
                $display("timeout after %0d cycles without progress", quiet_cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // entered at a falling edge, leaves at a falling edge; valid is only lowered
    // when a gap is taken, so a back-to-back request keeps it high
    task automatic send_byte(input logic [7:0] c, input bit cs);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= '{data_byte: c, closing_single: cs};
        do @(posedge i_clk); while (o_in_stall);
        tracker.take_byte(i_in_req);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s, input bit cs);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], cs);
        end
    endtask

    // sender pauses until every expected result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (tracker.awaited_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] nib);
        if (nib < 4'd10) return DIG_0 + 8'(nib);
        return ($urandom_range(1) ? LOW_A : UP_A) + 8'(nib) - 8'd10;
    endfunction

    function automatic void put_unicode(logic [15:0] v);
        piece.push_back(jsu_pkg::CH_BSLASH);
        piece.push_back(jsu_pkg::CH_U);
        for (int i = 3; i >= 0; i--) begin
            piece.push_back(hex_char(v[i*4 +: 4]));
        end
    endfunction

    function automatic bit is_escape_letter(logic [7:0] c);
        foreach (ESC_LETTERS[i]) begin
            if (ESC_LETTERS[i] == c) return 1'b1;
        end
        return c == jsu_pkg::CH_U;
    endfunction

    // code unit for a single \u escape, leaning on the utf-8 length boundaries
    function automatic logic [15:0] pick_code_unit();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'($urandom_range(16'h007F));
            2:       return $urandom_range(1) ? 16'h007F : 16'h0080;
            3:       return 16'($urandom_range(16'h07FF, 16'h0080));
            4:       return 16'($urandom_range(16'hFFFF, 16'h0800));
            5:       return 16'($urandom_range(16'hDFFF, 16'hDC00));
            6:       return $urandom_range(1) ? 16'h07FF : 16'h0800;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic logic [15:0] pick_high_surrogate();
        case ($urandom_range(3))
            0:       return jsu_pkg::SURR_HI_LO;
            1:       return jsu_pkg::SURR_HI_TOP;
            default: return 16'($urandom_range(jsu_pkg::SURR_HI_TOP, jsu_pkg::SURR_HI_LO));
        endcase
    endfunction

    // builds one piece of string body: well-formed escapes with random content,
    // plain text and quotes, and a share of broken sequences
    function automatic void build_piece();
        int unsigned pick;
        int unsigned k;
        logic [7:0]  c;
        logic [3:0]  nib;
        piece.delete();
        pick = $urandom_range(99);
        if (pick < 35) begin
            piece.push_back(8'($urandom_range(255)));
        end else if (pick < 40) begin
            piece.push_back($urandom_range(1) ? jsu_pkg::CH_DQUOTE : jsu_pkg::CH_SQUOTE);
        end else if (pick < 55) begin
            piece.push_back(jsu_pkg::CH_BSLASH);
            piece.push_back(ESC_LETTERS[$urandom_range(8)]);
        end else if (pick < 68) begin
            put_unicode(pick_code_unit());
        end else if (pick < 82) begin
            // surrogate pair, now and then with a second half that is no low surrogate
            put_unicode(pick_high_surrogate());
            k = $urandom_range(9);
            case (k)
                0:       put_unicode(16'hDC00);
                1:       put_unicode(16'hDFFF);
                9:       put_unicode(pick_code_unit());
                default: put_unicode(16'($urandom_range(16'hDFFF, 16'hDC00)));
            endcase
        end else if (pick < 88) begin
            // high surrogate not followed by a backslash and u
            put_unicode(pick_high_surrogate());
            if ($urandom_range(1)) begin
                do c = 8'($urandom_range(255)); while (c == jsu_pkg::CH_BSLASH);
                piece.push_back(c);
            end else begin
                piece.push_back(jsu_pkg::CH_BSLASH);
                do c = 8'($urandom_range(255)); while (c == jsu_pkg::CH_U);
                piece.push_back(c);
            end
        end else if (pick < 94) begin
            // unknown letter after a backslash, zero now and then
            piece.push_back(jsu_pkg::CH_BSLASH);
            if ($urandom_range(3) == 0) begin
                piece.push_back(NUL);
            end else begin
                do c = 8'($urandom_range(255)); while (is_escape_letter(c));
                piece.push_back(c);
            end
        end else begin
            // non-hex byte somewhere among the four digits
            piece.push_back(jsu_pkg::CH_BSLASH);
            piece.push_back(jsu_pkg::CH_U);
            k = $urandom_range(3);
            repeat (k) piece.push_back(hex_char(4'($urandom_range(15))));
            if ($urandom_range(3) == 0) begin
                piece.push_back(NUL);
            end else begin
                do c = 8'($urandom_range(255)); while (tracker.hex_nibble(c, nib));
                piece.push_back(c);
            end
        end
    endfunction

    initial begin
        int unsigned phase_end;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_req   = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, no idling: byte extremes, both quote kinds,
        // end of string, missing terminator, bad escapes, a surrogate pair
        // that needs all four utf-8 bytes, and the escaped zero code point
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(jsu_pkg::CH_SQUOTE, 1'b0);
        send_byte(jsu_pkg::CH_DQUOTE, 1'b0);
        send_byte(jsu_pkg::CH_SQUOTE, 1'b1);
        send_byte(NUL, 1'b0);
        send_text("\\q", 1'b0);
        send_byte(jsu_pkg::CH_BSLASH, 1'b1);
        send_byte(NUL, 1'b1);
        send_text("\\uD83d\\ude00", 1'b0);
        send_text("\\u0000", 1'b1);
        drain_results();

        // random phases: no idling (with one long receiver hold-off so the
        // unit backs up and stalls its input), sender idling, receiver
        // stalling, then both
        for (int p = 0; p < 4; p++) begin
            case (p)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 72; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 72; end
                default: begin send_idle_pct = 23; stall_pct = 23; end
            endcase
            if (p == 0) hold_off_go = 1'b1;
            phase_end = items_sent + PhaseItems;
            while (items_sent < phase_end) begin
                build_piece();
                foreach (piece[i]) begin
                    send_byte(piece[i], 1'($urandom_range(1)));
                end
            end
            drain_results();
        end

        // quiet tail to catch any stray result
        repeat (DrainCycles) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.awaited_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/jsu_pkg.sv
rtl/jsu_decode.sv
rtl/jsu_burst.sv
rtl/json_string_unescape_utf8_unit.sv
verif/json_string_unescape_utf8_unit_test.sv
